/* design/sacc_pkg.sv */
`default_nettype none
package sacc_pkg;

  // item field widths
  localparam int OPCODE_W = 2;
  localparam int ENC_W    = 13;
  localparam int RPM_W    = 16;
  localparam int TGT_W    = 32;
  localparam int CMD_W    = 16;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // defaults for the top level parameters
  localparam int ENC_PERIOD_DEF = 8192;
  localparam int HOLD_TICKS_DEF = 500;
  localparam int FRAC_BITS_DEF  = 16;

  // datapath widths
  localparam int GAIN_W   = 32;
  localparam int MAG_W    = 50;   // magnitude of any multiplier operand
  localparam int CAP_BITS = 40;   // products saturate at 2^40
  localparam int HP_SPLIT = 25;   // high-part split of the saturation test
  localparam int HP_LIMIT = 38;
  localparam int STATE_W  = 48;
  localparam int STALL_W  = 10;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int SQ_W     = 64;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TARGET  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ENABLE  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_DISABLE = 2'd3;

  // modes
  localparam logic [MODE_W-1:0] MODE_POS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HOME = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SPDLIM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_MODE = 3'd7;

  // register reset values
  localparam int CUR_LIM_W = 21;
  localparam logic [CUR_LIM_W-1:0] CUR_LIMIT_RST = 21'd1310720;
  localparam logic [31:0] RAMP_STEP_RST  = 32'd196608000;
  localparam logic [31:0] POS_SPDLIM_RST = 32'd16384000;

  // fixed constants of the loop
  localparam int HOMING_SPEED = 160;
  localparam int STALL_SPEED  = 2;
  localparam logic [31:0] RPM_DIVISOR = 32'd60000;
  localparam logic [31:0] RPM_ROUND   = 32'd30000;
  localparam logic [31:0] BRAKE_DIV   = 32'd5;
  localparam int CMD_SCALE_SHIFT = 12;
  localparam logic [CMD_W-1:0] CMD_MAX = 16'd16384;

endpackage
`default_nettype wire

/* design/sacc_in_if.sv */
`default_nettype none
interface sacc_in_if;
  import sacc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [ENC_W-1:0]           encoder_count;
  logic signed [RPM_W-1:0]    motor_rpm;
  logic signed [TGT_W-1:0]    target_value;
  modport source(output valid, opcode, encoder_count, motor_rpm, target_value, input ready);
  modport sink(input valid, opcode, encoder_count, motor_rpm, target_value, output ready);
endinterface
`default_nettype wire

/* design/sacc_out_if.sv */
`default_nettype none
interface sacc_out_if;
  import sacc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CMD_W-1:0]  current_cmd;
  logic [MODE_W-1:0]        mode_now;
  logic                     axis_enabled;
  logic signed [POS_W-1:0]  position_now;
  logic                     homing_done;
  modport source(output valid, current_cmd, mode_now, axis_enabled, position_now,
                 homing_done, input ready);
  modport sink(input valid, current_cmd, mode_now, axis_enabled, position_now,
               homing_done, output ready);
endinterface
`default_nettype wire

/* design/sacc_cfg_if.sv */
`default_nettype none
interface sacc_cfg_if;
  import sacc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DAT_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/sacc_mul.sv */
`default_nettype none
// Shift-add multiplier, one gain bit per cycle. Gives the raw product and the
// saturated magnitude min(prod >> shift, 2^40).
module sacc_mul #(
  parameter int FRAC_BITS = sacc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sacc_pkg::GAIN_W-1:0]   gain,
  input  wire logic [sacc_pkg::MAG_W-1:0]    mag,
  input  wire logic                          shift_en,
  output logic                               done,
  output logic [63:0]                        raw,
  output logic [sacc_pkg::CAP_BITS:0]        sat
);
  import sacc_pkg::*;

  localparam int ACC_W = MAG_W + GAIN_W;
  localparam int HI_W  = MAG_W - HP_SPLIT + GAIN_W;
  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic [ACC_W-1:0] CAP = ACC_W'(1) << CAP_BITS;

  logic [ACC_W-1:0]  a_r, acc_r;
  logic [HI_W-1:0]   ah_r, hacc_r;
  logic [GAIN_W-1:0] g_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r, done_r, shift_r;
  logic [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r     <= ACC_W'(mag);
        ah_r    <= HI_W'(mag >> HP_SPLIT);
        g_r     <= gain;
        acc_r   <= '0;
        hacc_r  <= '0;
        shift_r <= shift_en;
        cnt_r   <= '0;
        run_r   <= 1'b1;
      end else if (run_r) begin
        if (g_r[0]) begin
          acc_r  <= acc_r + a_r;
          hacc_r <= hacc_r + ah_r;
        end
        a_r   <= a_r << 1;
        ah_r  <= ah_r << 1;
        g_r   <= g_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(GAIN_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    shifted = shift_r ? (acc_r >> FRAC_BITS) : acc_r;
    if ((hacc_r >> HP_LIMIT) != '0 || shifted > CAP) begin
      sat = (CAP_BITS + 1)'(CAP);
    end else begin
      sat = shifted[CAP_BITS:0];
    end
  end

  assign raw  = acc_r[63:0];
  assign done = done_r;

endmodule
`default_nettype wire

/* design/sacc_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module sacc_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [sacc_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [sacc_pkg::DIV_DEN_W-1:0]   den,
  output logic                                  done,
  output logic [sacc_pkg::DIV_NUM_W-1:0]        quo
);
  import sacc_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic [DIV_NUM_W-1:0] n_r;
  logic [DIV_DEN_W-1:0] rem_r, d_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 run_r, done_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;

  assign trial = {rem_r, n_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        n_r   <= num;
        d_r   <= den;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? DIV_DEN_W'(trial - {1'b0, d_r}) : trial[DIV_DEN_W-1:0];
        n_r   <= {n_r[DIV_NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo  = n_r;
  assign done = done_r;

endmodule
`default_nettype wire

/* design/sacc_sqrt.sv */
`default_nettype none
// Floor square root, two radicand bits per cycle.
module sacc_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [sacc_pkg::SQ_W-1:0]   x,
  output logic                             done,
  output logic [sacc_pkg::SQ_W/2-1:0]      root
);
  import sacc_pkg::*;

  logic [SQ_W-1:0] x_r, res_r, bit_r;
  logic            run_r, done_r;
  logic [SQ_W:0]   trial;
  logic            ge;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign ge    = {1'b0, x_r} >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r   <= x;
        res_r <= '0;
        bit_r <= SQ_W'(1) << (SQ_W - 2);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (ge) begin
          x_r   <= x_r - trial[SQ_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = res_r[SQ_W/2-1:0];
  assign done = done_r;

endmodule
`default_nettype wire

/* design/servo_axis_cascade_controller_core.sv */
`default_nettype none
// One servo axis: cascaded position PD / velocity PI loop in fixed point with
// FRAC_BITS fraction bits. Every item gives exactly one result item. Set target,
// enable and disable go from the dispatch state straight to the result state. A
// tick runs on three bit-serial units that are used one after another: a shift-add
// multiplier (one gain bit a cycle), a restoring divider (one quotient bit a cycle)
// and a square root (two radicand bits a cycle). In position mode a tick uses five
// products, up to three divides and one root; in speed and homing mode it uses two
// products and two divides, and while the axis is disabled only the speed divide.
// One item is in work at a time; the result register lets the next item in while a
// result still waits to be taken. Configuration writes are taken in any cycle and
// must only be issued while the block is idle.
module servo_axis_cascade_controller_core #(
  parameter int ENCODER_PERIOD    = sacc_pkg::ENC_PERIOD_DEF,
  parameter int HOMING_HOLD_TICKS = sacc_pkg::HOLD_TICKS_DEF,
  parameter int FRAC_BITS         = sacc_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sacc_in_if.sink    in_if,
  sacc_out_if.source out_if,
  sacc_cfg_if.sink   cfg_if
);
  import sacc_pkg::*;

  localparam int DW = 19;
  localparam logic signed [DW-1:0] PERIOD_S = DW'(ENCODER_PERIOD);
  localparam logic signed [DW-1:0] HALF_S   = DW'(ENCODER_PERIOD / 2);
  localparam logic [STATE_W-1:0] HOMING_SPD = STATE_W'(HOMING_SPEED) << FRAC_BITS;
  localparam logic [STATE_W-1:0] STALL_LIM  = STATE_W'(STALL_SPEED) << FRAC_BITS;
  localparam logic [31:0] HOLD_AMPS  = 32'((64'(4) << FRAC_BITS) / 5);
  localparam logic [31:0] CMD_DEN    = 32'(5) << FRAC_BITS;
  localparam logic [31:0] CMD_DEN_HF = CMD_DEN >> 1;
  localparam logic [63:0] RAD_MAX    = '1;
  localparam logic [63:0] P_OVF      = RAD_MAX / 7;
  localparam logic [63:0] RAD_SH_MAX = RAD_MAX >> FRAC_BITS;
  localparam logic [STALL_W-1:0] HOLD_TICKS = STALL_W'(HOMING_HOLD_TICKS);
  localparam logic [STALL_W-1:0] STALL_MAX  = '1;
  localparam int CW = 50;   // width of clamp arithmetic

  // sequencer states
  localparam int SW = 5;
  localparam logic [SW-1:0] ST_IDLE  = 5'd0;
  localparam logic [SW-1:0] ST_DISP  = 5'd1;
  localparam logic [SW-1:0] ST_SPD   = 5'd2;
  localparam logic [SW-1:0] ST_MODE  = 5'd3;
  localparam logic [SW-1:0] ST_PE_S  = 5'd4;
  localparam logic [SW-1:0] ST_MKP   = 5'd5;
  localparam logic [SW-1:0] ST_MKD   = 5'd6;
  localparam logic [SW-1:0] ST_MRP   = 5'd7;
  localparam logic [SW-1:0] ST_DIV5  = 5'd8;
  localparam logic [SW-1:0] ST_SQRT  = 5'd9;
  localparam logic [SW-1:0] ST_RAMP  = 5'd10;
  localparam logic [SW-1:0] ST_EV    = 5'd11;
  localparam logic [SW-1:0] ST_PI_S  = 5'd12;
  localparam logic [SW-1:0] ST_MKI   = 5'd13;
  localparam logic [SW-1:0] ST_MKV   = 5'd14;
  localparam logic [SW-1:0] ST_CMD_S = 5'd15;
  localparam logic [SW-1:0] ST_CMD   = 5'd16;
  localparam logic [SW-1:0] ST_FIN   = 5'd17;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [MAG_W-1:0] absmag(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic signed [CW-1:0] signed_mag(input logic neg,
                                                      input logic [CAP_BITS:0] m);
    logic signed [CW-1:0] s;
    s = $signed(CW'(m));
    return neg ? -s : s;
  endfunction

  function automatic logic signed [CW-1:0] clampsym(input logic signed [CW-1:0] v,
                                                    input logic [31:0] lim);
    logic signed [CW-1:0] l;
    l = $signed(CW'(lim));
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // configuration
  logic [GAIN_W-1:0]    vel_kp_r, vel_ki_r, ramp_step_r, pos_kp_r, pos_kd_r, pos_spdlim_r;
  logic [CUR_LIM_W-1:0] cur_lim_r;

  // axis state
  logic [ENC_W-1:0]          last_enc_r;
  logic signed [31:0]        pos_r, des_pos_r, prev_err_r;
  logic signed [STATE_W-1:0] spd_cmd_r, ramped_r, integ_r;
  logic [STALL_W-1:0]        stall_r;
  logic [MODE_W-1:0]         mode_r;
  logic                      en_r;

  // item and work registers
  logic [SW-1:0]             state_r;
  logic [OPCODE_W-1:0]       op_r;
  logic [ENC_W-1:0]          enc_r;
  logic signed [RPM_W-1:0]   rpm_r;
  logic signed [TGT_W-1:0]   tgt_r;
  logic signed [STATE_W-1:0] speed_r;
  logic signed [31:0]        err_r, derr_r;
  logic signed [CW-1:0]      pd_r, ev_r, amps_r;
  logic signed [CMD_W-1:0]   cmd_r;
  logic                      done_r;

  // result register
  logic                      out_valid_r;
  logic signed [CMD_W-1:0]   out_cmd_r;
  logic [MODE_W-1:0]         out_mode_r;
  logic                      out_en_r;
  logic signed [POS_W-1:0]   out_pos_r;
  logic                      out_done_r;

  // serial units
  logic                  mul_start, mul_shift, mul_done;
  logic [GAIN_W-1:0]     mul_gain;
  logic [MAG_W-1:0]      mul_mag;
  logic [63:0]           mul_raw;
  logic [CAP_BITS:0]     mul_sat;
  logic                  div_start, div_done;
  logic [DIV_NUM_W-1:0]  div_num, div_quo;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  sq_start, sq_done;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W/2-1:0]     sq_root;

  sacc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk, .rst_n, .start(mul_start), .gain(mul_gain), .mag(mul_mag),
    .shift_en(mul_shift), .done(mul_done), .raw(mul_raw), .sat(mul_sat)
  );

  sacc_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  sacc_sqrt u_sqrt (
    .clk, .rst_n, .start(sq_start), .x(sq_x), .done(sq_done), .root(sq_root)
  );

  // combinational helpers
  logic signed [DW-1:0]      delta;
  logic signed [31:0]        pos_nxt, err_c;
  logic [RPM_W:0]            rpm_mag;
  logic [63:0]               spd_num, p7, rad_c;
  logic [MAG_W-1:0]          err_mag, derr_mag, ev_mag;
  logic signed [CW-1:0]      mul_s, pd_abs, brake_s, pd_lim, ramp_v, cmd_v, r_v;
  logic signed [CW-1:0]      integ_nxt, pi_v, amps_c;
  logic [STATE_W-1:0]        speed_abs;
  logic [CW-1:0]             amps_mag;
  logic [CMD_W-1:0]          cmd_mag;
  logic                      homing_end;

  always_comb begin
    delta = $signed({{(DW-ENC_W){1'b0}}, enc_r}) - $signed({{(DW-ENC_W){1'b0}}, last_enc_r});
    if (delta > HALF_S) begin
      delta = delta - PERIOD_S;
    end else if (delta < -HALF_S) begin
      delta = delta + PERIOD_S;
    end
    pos_nxt = sat32(33'(pos_r) + 33'(delta));

    rpm_mag = rpm_r[RPM_W-1] ? (RPM_W+1)'(-$signed({rpm_r[RPM_W-1], rpm_r}))
                             : (RPM_W+1)'(rpm_r);
    spd_num = ((64'(rpm_mag) * 64'(ENCODER_PERIOD)) << FRAC_BITS) + 64'(RPM_ROUND);

    err_c  = sat32(33'(des_pos_r) - 33'(pos_r));
    err_mag  = absmag(MAG_W'(err_r));
    derr_mag = absmag(MAG_W'(derr_r));
    ev_mag   = absmag(ev_r);

    p7 = (mul_raw << 3) - mul_raw;
    rad_c = (div_quo > RAD_SH_MAX) ? RAD_MAX : (div_quo << FRAC_BITS);

    // braking curve limit, then speed clamp
    pd_abs  = pd_r[CW-1] ? -pd_r : pd_r;
    brake_s = $signed(CW'(sq_root));
    if (brake_s < pd_abs) begin
      pd_lim = err_r[31] ? -brake_s : brake_s;
    end else begin
      pd_lim = pd_r;
    end
    pd_lim = clampsym(pd_lim, pos_spdlim_r);

    // slew ramp
    ramp_v = CW'(ramped_r);
    cmd_v  = CW'(spd_cmd_r);
    r_v    = $signed(CW'(ramp_step_r));
    if (ramp_v < cmd_v - r_v) begin
      ramp_v = ramp_v + r_v;
    end else if (ramp_v > cmd_v + r_v) begin
      ramp_v = ramp_v - r_v;
    end else begin
      ramp_v = cmd_v;
    end

    mul_s     = signed_mag(ev_r[CW-1], mul_sat);
    integ_nxt = clampsym(CW'(integ_r) + mul_s, 32'(cur_lim_r));
    pi_v      = clampsym(mul_s + CW'(integ_r), 32'(cur_lim_r));
    amps_c    = (mode_r == MODE_HOME) ? clampsym(pi_v, HOLD_AMPS) : pi_v;
    homing_end = (mode_r == MODE_HOME) && (stall_r >= HOLD_TICKS);

    speed_abs = speed_r[STATE_W-1] ? STATE_W'(-speed_r) : STATE_W'(speed_r);
    amps_mag  = amps_r[CW-1] ? CW'(-amps_r) : CW'(amps_r);
    cmd_mag   = (div_quo > 64'(CMD_MAX)) ? CMD_MAX : div_quo[CMD_W-1:0];
  end

  // unit starts and operands
  always_comb begin
    mul_start = 1'b0;
    mul_gain  = pos_kp_r;
    mul_mag   = err_mag;
    mul_shift = 1'b0;
    div_start = 1'b0;
    div_num   = spd_num;
    div_den   = RPM_DIVISOR;
    sq_start  = 1'b0;
    sq_x      = rad_c;
    unique case (state_r)
      ST_DISP: begin
        div_start = (op_r == OP_TICK);
      end
      ST_PE_S: begin
        mul_start = 1'b1;
      end
      ST_MKP: begin
        mul_start = mul_done;
        mul_gain  = pos_kd_r;
        mul_mag   = derr_mag;
      end
      ST_MKD: begin
        mul_start = mul_done;
        mul_gain  = ramp_step_r;
      end
      ST_MRP: begin
        div_start = mul_done && (mul_raw <= P_OVF);
        div_num   = p7;
        div_den   = BRAKE_DIV;
        sq_start  = mul_done && (mul_raw > P_OVF);
        sq_x      = RAD_MAX;
      end
      ST_DIV5: begin
        sq_start = div_done;
      end
      ST_PI_S: begin
        mul_start = 1'b1;
        mul_gain  = vel_ki_r;
        mul_mag   = ev_mag;
        mul_shift = 1'b1;
      end
      ST_MKI: begin
        mul_start = mul_done;
        mul_gain  = vel_kp_r;
        mul_mag   = ev_mag;
        mul_shift = 1'b1;
      end
      ST_CMD_S: begin
        div_start = 1'b1;
        div_num   = (64'(amps_mag) << CMD_SCALE_SHIFT) + 64'(CMD_DEN_HF);
        div_den   = CMD_DEN;
      end
      default: begin
      end
    endcase
  end

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vel_kp_r     <= '0;
      vel_ki_r     <= '0;
      cur_lim_r    <= CUR_LIMIT_RST;
      ramp_step_r  <= RAMP_STEP_RST;
      pos_kp_r     <= '0;
      pos_kd_r     <= '0;
      pos_spdlim_r <= POS_SPDLIM_RST;
      last_enc_r   <= '0;
      pos_r        <= '0;
      des_pos_r    <= '0;
      prev_err_r   <= '0;
      spd_cmd_r    <= '0;
      ramped_r     <= '0;
      integ_r      <= '0;
      stall_r      <= '0;
      mode_r       <= MODE_POS;
      en_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      // ST_FIN reloads the result register in the cycle it is taken
      if (out_valid_r && out_if.ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_if.valid) begin
            op_r    <= in_if.opcode;
            enc_r   <= in_if.encoder_count;
            rpm_r   <= in_if.motor_rpm;
            tgt_r   <= in_if.target_value;
            state_r <= ST_DISP;
          end
        end
        ST_DISP: begin
          done_r <= 1'b0;
          cmd_r  <= '0;
          unique case (op_r)
            OP_TICK: begin
              last_enc_r <= enc_r;
              pos_r      <= pos_nxt;
              state_r    <= ST_SPD;
            end
            OP_TARGET: begin
              if (mode_r == MODE_POS) begin
                des_pos_r <= tgt_r;
              end else if (mode_r == MODE_SPD) begin
                spd_cmd_r <= STATE_W'(tgt_r);
              end
              state_r <= ST_FIN;
            end
            OP_ENABLE: begin
              if (mode_r == MODE_POS) begin
                des_pos_r <= pos_r;
              end
              if (mode_r == MODE_SPD) begin
                spd_cmd_r <= '0;
              end
              integ_r <= '0;
              en_r    <= 1'b1;
              state_r <= ST_FIN;
            end
            OP_DISABLE: begin
              en_r    <= 1'b0;
              state_r <= ST_FIN;
            end
          endcase
        end
        ST_SPD: begin
          if (div_done) begin
            speed_r <= rpm_r[RPM_W-1] ? -$signed(div_quo[STATE_W-1:0])
                                      : $signed(div_quo[STATE_W-1:0]);
            state_r <= en_r ? ST_MODE : ST_FIN;
          end
        end
        ST_MODE: begin
          if (mode_r == MODE_HOME) begin
            ramped_r <= -$signed(HOMING_SPD);
            ev_r     <= -$signed(CW'(HOMING_SPD)) - CW'(speed_r);
            if (speed_abs <= STALL_LIM) begin
              if (stall_r != STALL_MAX) begin
                stall_r <= stall_r + 1'b1;
              end
            end else begin
              stall_r <= '0;
            end
            state_r <= ST_PI_S;
          end else if (mode_r == MODE_POS) begin
            err_r      <= err_c;
            derr_r     <= sat32(33'(err_c) - 33'(prev_err_r));
            prev_err_r <= err_c;
            state_r    <= ST_PE_S;
          end else begin
            state_r <= ST_RAMP;
          end
        end
        ST_PE_S: begin
          state_r <= ST_MKP;
        end
        ST_MKP: begin
          if (mul_done) begin
            pd_r    <= signed_mag(err_r[31], mul_sat);
            state_r <= ST_MKD;
          end
        end
        ST_MKD: begin
          if (mul_done) begin
            pd_r    <= pd_r + signed_mag(derr_r[31], mul_sat);
            state_r <= ST_MRP;
          end
        end
        ST_MRP: begin
          if (mul_done) begin
            state_r <= (mul_raw > P_OVF) ? ST_SQRT : ST_DIV5;
          end
        end
        ST_DIV5: begin
          if (div_done) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            spd_cmd_r <= STATE_W'(pd_lim);
            state_r   <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          ramped_r <= STATE_W'(ramp_v);
          state_r  <= ST_EV;
        end
        ST_EV: begin
          ev_r    <= CW'(ramped_r) - CW'(speed_r);
          state_r <= ST_PI_S;
        end
        ST_PI_S: begin
          state_r <= ST_MKI;
        end
        ST_MKI: begin
          if (mul_done) begin
            integ_r <= STATE_W'(integ_nxt);
            state_r <= ST_MKV;
          end
        end
        ST_MKV: begin
          if (mul_done) begin
            if (homing_end) begin
              pos_r     <= '0;
              des_pos_r <= 32'(ENCODER_PERIOD);
              spd_cmd_r <= '0;
              ramped_r  <= '0;
              integ_r   <= '0;
              stall_r   <= '0;
              mode_r    <= MODE_POS;
              done_r    <= 1'b1;
              amps_r    <= '0;
            end else begin
              amps_r <= amps_c;
            end
            state_r <= ST_CMD_S;
          end
        end
        ST_CMD_S: begin
          state_r <= ST_CMD;
        end
        ST_CMD: begin
          if (div_done) begin
            cmd_r   <= amps_r[CW-1] ? -$signed(cmd_mag) : $signed(cmd_mag);
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_cmd_r   <= cmd_r;
            out_mode_r  <= mode_r;
            out_en_r    <= en_r;
            out_pos_r   <= pos_r;
            out_done_r  <= done_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          REG_VEL_KP:     vel_kp_r     <= cfg_if.data;
          REG_VEL_KI:     vel_ki_r     <= cfg_if.data;
          REG_CUR_LIMIT:  cur_lim_r    <= cfg_if.data[CUR_LIM_W-1:0];
          REG_RAMP_STEP:  ramp_step_r  <= cfg_if.data;
          REG_POS_KP:     pos_kp_r     <= cfg_if.data;
          REG_POS_KD:     pos_kd_r     <= cfg_if.data;
          REG_POS_SPDLIM: pos_spdlim_r <= cfg_if.data;
          REG_START_MODE: begin
            mode_r  <= (cfg_if.data[MODE_W-1:0] == MODE_BAD) ? MODE_POS
                                                             : cfg_if.data[MODE_W-1:0];
            stall_r <= '0;
          end
        endcase
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.current_cmd  = out_cmd_r;
  assign out_if.mode_now     = out_mode_r;
  assign out_if.axis_enabled = out_en_r;
  assign out_if.position_now = out_pos_r;
  assign out_if.homing_done  = out_done_r;

  // homing completes into position mode at the zero point
  a_home_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_mode_r == MODE_POS && out_pos_r == '0)
    else $error("homing result not at zero in position mode");

  // a disabled axis never drives current
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_en_r |-> out_cmd_r == '0)
    else $error("current command while disabled");

  // stall counting only runs while homing
  a_stall_home: assert property (@(posedge clk) disable iff (!rst_n)
    stall_r != '0 |-> mode_r == MODE_HOME)
    else $error("stall count outside homing");

endmodule
`default_nettype wire

/* sim/tb_servo_axis_cascade_controller_core.sv */
`timescale 1ns / 1ps
module tb_servo_axis_cascade_controller_core;
  import sacc_pkg::*;

  typedef struct packed {
    logic [OPCODE_W-1:0]     opcode;
    logic [ENC_W-1:0]        encoder_count;
    logic signed [RPM_W-1:0] motor_rpm;
    logic signed [TGT_W-1:0] target_value;
  } axis_item_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] current_cmd;
    logic [MODE_W-1:0]       mode_now;
    logic                    axis_enabled;
    logic signed [POS_W-1:0] position_now;
    logic                    homing_done;
  } axis_result_t;

  localparam longint CAP = 64'sd1 << 40;
  localparam longint LIMIT_CYCLES = 64'd6000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sacc_in_if  in_if();
  sacc_out_if out_if();
  sacc_cfg_if cfg_if();

  servo_axis_cascade_controller_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  // shadow of the loop state
  logic [31:0] g_vel_kp, g_vel_ki, g_cur_lim, g_ramp, g_pos_kp, g_pos_kd, g_spd_lim;
  logic [12:0] s_last_enc;
  logic [9:0]  s_stall;
  logic [1:0]  s_mode;
  logic        s_enabled;
  int          s_pos, s_desired, s_prev_err;
  longint      s_speed_cmd, s_ramped, s_integral;

  axis_item_t   pending_items[$];
  axis_result_t expected_results[$];
  int     errors = 0;
  int     results_seen = 0;
  int     ticks_sent = 0;
  int     homings_done = 0;
  longint cycle = 0;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // sign(v) * min((|v|*g) >> sh, 2^40), exact over 128 bits
  function automatic longint gain_product(logic [31:0] g, longint v, int sh);
    logic [127:0] a, r;
    a = (v < 0) ? 128'(-v) : 128'(v);
    r = (a * 128'(g)) >> sh;
    if (r > 128'(CAP)) r = 128'(CAP);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint position_speed_cmd();
    int e, d;
    longint pd, pdm;
    logic [127:0] p;
    logic [63:0] rad, brk;
    e = sat32(longint'(s_desired) - longint'(s_pos));
    d = sat32(longint'(e) - longint'(s_prev_err));
    pd = gain_product(g_pos_kp, e, 0) + gain_product(g_pos_kd, d, 0);
    pdm = pd < 0 ? -pd : pd;
    s_prev_err = e;
    p = 128'(g_ramp) * 128'((e < 0) ? -longint'(e) : longint'(e));
    if (p > 128'(64'hffffffffffffffff / 7)) begin
      rad = '1;
    end else begin
      p = p * 7 / 5;
      rad = (p > 128'(64'hffffffffffffffff >> 16)) ? '1 : 64'(p << 16);
    end
    brk = floor_sqrt(rad);
    if (longint'(brk) < pdm) pd = (e < 0) ? -longint'(brk) : longint'(brk);
    return clamp_sym(pd, longint'(g_spd_lim));
  endfunction

  function automatic longint velocity_pi(longint spd);
    longint ev;
    ev = s_ramped - spd;
    s_integral = clamp_sym(s_integral + gain_product(g_vel_ki, ev, 16), g_cur_lim);
    return clamp_sym(gain_product(g_vel_kp, ev, 16) + s_integral, g_cur_lim);
  endfunction

  function automatic axis_result_t predict_axis(axis_item_t it);
    axis_result_t r;
    longint delta, spd, amps, m, c, rpm;
    logic [63:0] mag;
    r = '0;
    amps = 0;
    c = 0;
    if (it.opcode == OP_TICK) begin
      delta = longint'(it.encoder_count) - longint'(s_last_enc);
      if (delta > 4096) delta -= 8192;
      if (delta < -4096) delta += 8192;
      s_last_enc = it.encoder_count;
      s_pos = sat32(longint'(s_pos) + delta);
      rpm = it.motor_rpm;
      mag = 64'((rpm < 0) ? -rpm : rpm) * 64'd8192;
      mag = ((mag << 16) + 64'd30000) / 64'd60000;
      spd = (rpm < 0) ? -longint'(mag) : longint'(mag);
      if (s_enabled) begin
        if (s_mode == MODE_HOME) begin
          s_ramped = -(64'sd160 <<< 16);
          amps = clamp_sym(velocity_pi(spd), (64'sd4 <<< 16) / 5);
          if (((spd < 0) ? -spd : spd) <= (64'sd2 <<< 16)) begin
            if (s_stall < 10'd1023) s_stall++;
          end else begin
            s_stall = 0;
          end
          if (s_stall >= 10'd500) begin
            s_pos = 0;
            s_desired = 8192;
            s_speed_cmd = 0;
            s_ramped = 0;
            s_integral = 0;
            amps = 0;
            s_stall = 0;
            s_mode = MODE_POS;
            r.homing_done = 1'b1;
          end
        end else begin
          if (s_mode == MODE_POS) s_speed_cmd = position_speed_cmd();
          if (s_ramped < s_speed_cmd - longint'(g_ramp)) s_ramped += longint'(g_ramp);
          else if (s_ramped > s_speed_cmd + longint'(g_ramp)) s_ramped -= longint'(g_ramp);
          else s_ramped = s_speed_cmd;
          amps = velocity_pi(spd);
        end
        m = (amps < 0) ? -amps : amps;
        c = (m * 4096 + (64'sd5 <<< 15)) / (64'sd5 <<< 16);
        if (c > 16384) c = 16384;
        if (amps < 0) c = -c;
      end
    end else if (it.opcode == OP_TARGET) begin
      if (s_mode == MODE_POS) s_desired = it.target_value;
      else if (s_mode == MODE_SPD) s_speed_cmd = it.target_value;
    end else if (it.opcode == OP_ENABLE) begin
      if (s_mode == MODE_POS) s_desired = s_pos;
      if (s_mode == MODE_SPD) s_speed_cmd = 0;
      s_integral = 0;
      s_enabled = 1'b1;
    end else begin
      s_enabled = 1'b0;
    end
    r.current_cmd = c[15:0];
    r.mode_now = s_mode;
    r.axis_enabled = s_enabled;
    r.position_now = s_pos;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_if.valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      axis_item_t it;
      it = pending_items.pop_front();
      expected_results.push_back(predict_axis(it));
      if (it.opcode == OP_TICK) ticks_sent++;
      in_if.valid <= 1'b1;
      in_if.opcode <= it.opcode;
      in_if.encoder_count <= it.encoder_count;
      in_if.motor_rpm <= it.motor_rpm;
      in_if.target_value <= it.target_value;
      in_gap <= gap_len();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        axis_result_t got, want;
        got = '{out_if.current_cmd, out_if.mode_now, out_if.axis_enabled,
                out_if.position_now, out_if.homing_done};
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("result %0d: no result was due", results_seen);
        end else begin
          want = expected_results.pop_front();
          if (got.homing_done) homings_done++;
          if (got.current_cmd !== want.current_cmd)
            report_mismatch("current_cmd", got.current_cmd, want.current_cmd);
          if (got.mode_now !== want.mode_now)
            report_mismatch("mode_now", got.mode_now, want.mode_now);
          if (got.axis_enabled !== want.axis_enabled)
            report_mismatch("axis_enabled", got.axis_enabled, want.axis_enabled);
          if (got.position_now !== want.position_now)
            report_mismatch("position_now", got.position_now, want.position_now);
          if (got.homing_done !== want.homing_done)
            report_mismatch("homing_done", got.homing_done, want.homing_done);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
      end
    end
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycle);
      $display("tb_servo_axis_cascade_controller_core NOT OK");
      $finish;
    end
  end

  task automatic add_item(logic [1:0] op, logic [12:0] enc, logic [15:0] rpm,
                          logic [31:0] tgt);
    axis_item_t it;
    it.opcode = op;
    it.encoder_count = enc;
    it.motor_rpm = rpm;
    it.target_value = tgt;
    pending_items.push_back(it);
  endtask

  // a register write takes effect in the shadow state right away: the block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_VEL_KP:     g_vel_kp = val;
      REG_VEL_KI:     g_vel_ki = val;
      REG_CUR_LIMIT:  g_cur_lim = {11'd0, val[20:0]};
      REG_RAMP_STEP:  g_ramp = val;
      REG_POS_KP:     g_pos_kp = val;
      REG_POS_KD:     g_pos_kd = val;
      REG_POS_SPDLIM: g_spd_lim = val;
      default: begin
        s_mode = (val[1:0] == MODE_BAD) ? MODE_POS : val[1:0];
        s_stall = 0;
      end
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_if.valid)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom_range(0, 1 << 16);
      3: return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // walks the encoder mostly by small steps so unwrap and loops stay busy
  logic [12:0] enc_walk = 0;
  task automatic add_random_items(int n, logic [1:0] mode);
    logic [31:0] tgt;
    logic [15:0] rpm;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: add_item(OP_ENABLE, $urandom, $urandom, $urandom);
        1: add_item(OP_DISABLE, $urandom, $urandom, $urandom);
        2, 3: begin
          if (mode == MODE_SPD) tgt = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
          else tgt = $signed($urandom_range(0, 20000)) - 10000;
          if ($urandom_range(0, 9) == 0) tgt = $urandom;
          add_item(OP_TARGET, $urandom, $urandom, tgt);
        end
        default: begin
          if ($urandom_range(0, 15) == 0) enc_walk = $urandom;
          else enc_walk = enc_walk + 13'($signed($urandom_range(0, 400)) - 200);
          rpm = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(0, 2000)) - 1000);
          add_item(OP_TICK, enc_walk, rpm, $urandom);
        end
      endcase
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_TICK;
    in_if.encoder_count = '0;
    in_if.motor_rpm = '0;
    in_if.target_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_VEL_KP;
    cfg_if.data = '0;
    g_vel_kp = 0; g_vel_ki = 0; g_cur_lim = 32'(CUR_LIMIT_RST);
    g_ramp = RAMP_STEP_RST; g_pos_kp = 0; g_pos_kd = 0; g_spd_lim = POS_SPDLIM_RST;
    s_last_enc = 0; s_stall = 0; s_mode = MODE_POS; s_enabled = 0;
    s_pos = 0; s_desired = 0; s_prev_err = 0;
    s_speed_cmd = 0; s_ramped = 0; s_integral = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, extremes and wrap of the encoder, all opcodes
    add_item(OP_TICK, 13'd8191, 16'sh7fff, 32'sh7fffffff);
    add_item(OP_ENABLE, 0, 0, 0);
    add_item(OP_TARGET, 0, 0, 32'sh80000000);
    add_item(OP_TICK, 13'd4095, 16'sh8000, 0);
    add_item(OP_TICK, 13'd0, 16'sh7fff, 0);
    add_item(OP_TICK, 13'd4096, 16'shffff, 0);
    add_item(OP_DISABLE, 13'h1fff, 16'hffff, 32'hffffffff);
    add_item(OP_TICK, 13'd100, 16'sd0, 0);
    wait_idle();
    write_reg(REG_VEL_KP, 32'hffffffff);
    write_reg(REG_VEL_KI, 32'hffffffff);
    write_reg(REG_CUR_LIMIT, 32'h1fffff);
    write_reg(REG_RAMP_STEP, 32'hffffffff);
    write_reg(REG_POS_KP, 32'hffffffff);
    write_reg(REG_POS_KD, 32'hffffffff);
    write_reg(REG_POS_SPDLIM, 32'hffffffff);
    write_reg(REG_START_MODE, {30'd0, MODE_POS});
    add_item(OP_ENABLE, 0, 0, 0);
    add_item(OP_TARGET, 0, 0, 32'sh7fffffff);
    add_item(OP_TICK, 13'd4000, 16'sh8000, 0);
    add_item(OP_TARGET, 0, 0, 32'sh80000000);
    add_item(OP_TICK, 13'd0, 16'sh7fff, 0);
    add_item(OP_TICK, 13'd5000, 16'sd0, 0);
    wait_idle();
    // mode three lands in position mode
    write_reg(REG_START_MODE, {30'd0, MODE_BAD});
    add_item(OP_TICK, 13'd5000, 16'sd0, 0);
    wait_idle();

    // random phases over several gain sets and modes
    for (int ph = 0; ph < 12; ph++) begin
      logic [1:0] md;
      md = (ph % 3 == 2) ? MODE_SPD : ((ph % 3 == 1) ? MODE_POS : 2'($urandom_range(0, 3)));
      write_reg(REG_VEL_KP, rand_gain());
      write_reg(REG_VEL_KI, rand_gain());
      write_reg(REG_CUR_LIMIT, (ph == 3) ? 32'd0 : $urandom_range(0, 1310720));
      write_reg(REG_RAMP_STEP, (ph == 4) ? 32'd0 : $urandom_range(0, 32'd300000000));
      write_reg(REG_POS_KP, rand_gain());
      write_reg(REG_POS_KD, rand_gain());
      write_reg(REG_POS_SPDLIM, (ph == 5) ? 32'd0 : rand_gain());
      write_reg(REG_START_MODE, {30'd0, md});
      add_item(OP_ENABLE, 0, 0, 0);
      add_random_items(50, md);
      wait_idle();
    end

    // homing: stalled ticks run to completion, some broken by motion
    for (int h = 0; h < 2; h++) begin
      write_reg(REG_VEL_KP, $urandom_range(0, 1 << 18));
      write_reg(REG_VEL_KI, $urandom_range(0, 1 << 12));
      write_reg(REG_START_MODE, {30'd0, MODE_HOME});
      add_item(OP_ENABLE, 0, 0, 0);
      add_item(OP_TARGET, 0, 0, $urandom);
      if (h == 1) begin
        add_item(OP_TICK, enc_walk, 16'sd300, 0);
        add_item(OP_TICK, enc_walk, 16'sd0, 0);
      end
      for (int i = 0; i < 120; i++) add_item(OP_TICK, enc_walk, 16'($urandom_range(0, 28)) - 16'sd14, 0);
      if (h == 0) add_item(OP_TICK, enc_walk, 16'sd500, 0);
      for (int i = 0; i < 505; i++) add_item(OP_TICK, enc_walk, 16'($urandom_range(0, 28)) - 16'sd14, 0);
      add_random_items(10, MODE_POS);
      wait_idle();
    end

    wait_idle();
    $display("covered %0d results, %0d ticks, %0d homing completions",
             results_seen, ticks_sent, homings_done);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_servo_axis_cascade_controller_core OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("tb_servo_axis_cascade_controller_core NOT OK");
    end
    $finish;
  end

endmodule
